// ===== src/palette_2bpp_lcd_blit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the palette LCD blitter
// Concurrent assertion helpers that are clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_2BPP_LCD_BLIT_ASSERT_SVH
`define PALETTE_2BPP_LCD_BLIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define P2LB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("palette_2bpp_lcd_blit: assertion failed");
`define P2LB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("palette_2bpp_lcd_blit: assertion failed");
`else
`define P2LB_ASSERT_IMP(lbl, ante, cons)
`define P2LB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/p2lb_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette LCD blitter package
// Shared types and constants for the 2-bit palette to RGB565 LCD stream block.
// ----------------------------------------------------------------------------
package p2lb_pkg;

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  localparam int HDR_LEN = 11;
  localparam int CNT_W   = 16;

  typedef enum logic [2:0] {
    REG_WIN_X,
    REG_WIN_Y,
    REG_IMG_WIDTH,
    REG_IMG_HEIGHT,
    REG_PAL_0,
    REG_PAL_1,
    REG_PAL_2,
    REG_PAL_3
  } reg_idx_e;

  typedef struct packed {
    logic [6:0]       win_x;
    logic [7:0]       win_y;
    logic [7:0]       img_width;
    logic [7:0]       img_height;
    logic [3:0][15:0] palette;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixels;
    logic       hdr;
    logic       rej;
    logic [1:0] last_pix;
    logic       done;
  } item_t;

endpackage

// ===== src/palette_2bpp_lcd_blit.sv =====
// ----------------------------------------------------------------------------
// Palette 2bpp LCD blitter
// Expands packed 2-bit palette pixels into an RGB565 LCD byte stream with
// a window set-up sequence at the start of each image.
//
//   channel    direction  handshake                      payload
//   s_axis     in         tvalid/tready                  packed pixel byte
//   m_axis     out        tvalid/tready, tlast           LCD byte and flags
//   apb        in/out     psel/penable/pwrite/pready     eight config registers
//
// An item that starts an image emits the 11-byte window header and then two
// bytes per pixel; later items emit only two bytes per pixel. The output
// sequencer's byte counter walks these bytes. A rejected item emits a
// single zero byte. One item waits in an input register while the
// previous one drains. Output stalls hold the current byte. Reset clears the
// pixel count and valid flags and sets the config registers to defaults.
// ----------------------------------------------------------------------------
`include "palette_2bpp_lcd_blit_assert.svh"

module palette_2bpp_lcd_blit #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // packed_pixels
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic [2:0]  m_axis_tuser,  // is_data, image_done, rejected
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import p2lb_pkg::*;

  localparam int PW_W   = $clog2(PANEL_WIDTH + 1);
  localparam int PH_W   = $clog2(PANEL_HEIGHT + 1);
  localparam int PM_W   = (PW_W > PH_W) ? PW_W : PH_W;
  localparam int CMP_W  = (PM_W > 9) ? PM_W : 9;

  cfg_t             cfg_q;
  logic [CNT_W-1:0] pixels_left_q;
  logic             a_valid_q;
  item_t            a_item_q;
  item_t            item_d;
  logic             seq_take;
  logic             s_hs;
  logic             cfg_wr;
  reg_idx_e         reg_idx;
  logic             start;
  logic             bad;
  logic [8:0]       sum_x;
  logic [8:0]       sum_y;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] avail;
  logic [2:0]       n_pix;
  logic [CNT_W-1:0] left_d;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_x      <= '0;
      cfg_q.win_y      <= '0;
      cfg_q.img_width  <= 8'd1;
      cfg_q.img_height <= 8'd1;
      cfg_q.palette    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIN_X:      cfg_q.win_x      <= pwdata[6:0];
        REG_WIN_Y:      cfg_q.win_y      <= pwdata[7:0];
        REG_IMG_WIDTH:  cfg_q.img_width  <= pwdata[7:0];
        REG_IMG_HEIGHT: cfg_q.img_height <= pwdata[7:0];
        REG_PAL_0:      cfg_q.palette[0] <= pwdata[15:0];
        REG_PAL_1:      cfg_q.palette[1] <= pwdata[15:0];
        REG_PAL_2:      cfg_q.palette[2] <= pwdata[15:0];
        REG_PAL_3:      cfg_q.palette[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIN_X:      prdata = {25'd0, cfg_q.win_x};
      REG_WIN_Y:      prdata = {24'd0, cfg_q.win_y};
      REG_IMG_WIDTH:  prdata = {24'd0, cfg_q.img_width};
      REG_IMG_HEIGHT: prdata = {24'd0, cfg_q.img_height};
      REG_PAL_0:      prdata = {16'd0, cfg_q.palette[0]};
      REG_PAL_1:      prdata = {16'd0, cfg_q.palette[1]};
      REG_PAL_2:      prdata = {16'd0, cfg_q.palette[2]};
      default:        prdata = {16'd0, cfg_q.palette[3]};
    endcase
  end

  assign start = (pixels_left_q == '0);
  assign sum_x = {2'b00, cfg_q.win_x} + {1'b0, cfg_q.img_width};
  assign sum_y = {1'b0, cfg_q.win_y} + {1'b0, cfg_q.img_height};
  assign bad   = (cfg_q.img_width == 8'd0) || (cfg_q.img_height == 8'd0) ||
                 (CMP_W'(sum_x) > CMP_W'(PANEL_WIDTH)) ||
                 (CMP_W'(sum_y) > CMP_W'(PANEL_HEIGHT));
  assign total = CNT_W'(cfg_q.img_width * cfg_q.img_height);
  assign avail = start ? total : pixels_left_q;
  assign n_pix = (avail < CNT_W'(4)) ? avail[2:0] : 3'd4;
  assign left_d = avail - CNT_W'(n_pix);

  always_comb begin
    item_d.pixels   = s_axis_tdata;
    item_d.hdr      = start && !bad;
    item_d.rej      = start && bad;
    item_d.last_pix = 2'(n_pix - 3'd1);
    item_d.done     = (left_d == '0);
  end

  assign s_axis_tready = !a_valid_q || seq_take;
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q     <= 1'b0;
      pixels_left_q <= '0;
    end else begin
      if (s_axis_tready) begin
        a_valid_q <= s_axis_tvalid;
      end
      if (s_hs && !item_d.rej) begin
        pixels_left_q <= left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      a_item_q <= item_d;
    end
  end

  p2lb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (a_valid_q),
    .item_i      (a_item_q),
    .cfg_i       (cfg_q),
    .take_o      (seq_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  `P2LB_ASSERT_IMP(a_rej_single, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast && !m_axis_tuser[0] && !m_axis_tuser[1])
  `P2LB_ASSERT_IMP(a_done_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
  `P2LB_ASSERT_IMP(a_no_rej_mid, s_hs && !start, !item_d.rej && !item_d.hdr)
  `P2LB_ASSERT_NXT(a_count_down, s_hs && !start, pixels_left_q < $past(pixels_left_q))

endmodule

// ===== src/p2lb_seq.sv =====
// ----------------------------------------------------------------------------
// Palette LCD blitter output sequencer
// Holds one item and walks through its window header, if any, and pixel bytes.
// ----------------------------------------------------------------------------
module p2lb_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  p2lb_pkg::item_t item_i,
  input  p2lb_pkg::cfg_t  cfg_i,
  output logic            take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      out_user_o, // is_data, image_done, rejected
  output logic            out_last_o
);
  import p2lb_pkg::*;

  logic        b_valid_q;
  item_t       b_item_q;
  logic        in_hdr_q;
  logic [3:0]  cnt_q;
  logic        last;
  logic        is_cmd;
  logic [8:0]  x1_sum;
  logic [8:0]  y1_sum;
  logic [15:0] x0;
  logic [15:0] x1;
  logic [15:0] y0;
  logic [15:0] y1;
  logic [1:0]  pix_idx;
  logic [15:0] color;
  logic [7:0]  hdr_byte;
  logic [7:0]  pix_byte;

  assign x1_sum = {2'b00, cfg_i.win_x} + {1'b0, cfg_i.img_width} - 9'd1;
  assign y1_sum = {1'b0, cfg_i.win_y} + {1'b0, cfg_i.img_height} - 9'd1;
  assign x0     = {9'd0, cfg_i.win_x};
  assign x1     = {7'd0, x1_sum};
  assign y0     = {8'd0, cfg_i.win_y};
  assign y1     = {7'd0, y1_sum};

  always_comb begin
    hdr_byte = CMD_RAMWR;
    is_cmd   = 1'b0;
    case (cnt_q)
      4'd0: begin
        hdr_byte = CMD_CASET;
        is_cmd   = 1'b1;
      end
      4'd1: hdr_byte = x0[15:8];
      4'd2: hdr_byte = x0[7:0];
      4'd3: hdr_byte = x1[15:8];
      4'd4: hdr_byte = x1[7:0];
      4'd5: begin
        hdr_byte = CMD_RASET;
        is_cmd   = 1'b1;
      end
      4'd6: hdr_byte = y0[15:8];
      4'd7: hdr_byte = y0[7:0];
      4'd8: hdr_byte = y1[15:8];
      4'd9: hdr_byte = y1[7:0];
      default: begin
        hdr_byte = CMD_RAMWR;
        is_cmd   = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (cnt_q[2:1])
      2'd0:    pix_idx = b_item_q.pixels[7:6];
      2'd1:    pix_idx = b_item_q.pixels[5:4];
      2'd2:    pix_idx = b_item_q.pixels[3:2];
      default: pix_idx = b_item_q.pixels[1:0];
    endcase
  end

  assign color    = cfg_i.palette[pix_idx];
  assign pix_byte = cnt_q[0] ? color[7:0] : color[15:8];

  assign last = b_item_q.rej || (!in_hdr_q && cnt_q[2:0] == {b_item_q.last_pix, 1'b1});

  assign out_valid_o = b_valid_q;
  assign out_last_o  = last;
  assign out_byte_o  = b_item_q.rej ? 8'd0 : (in_hdr_q ? hdr_byte : pix_byte);
  assign out_user_o  = {b_item_q.rej,
                        last && b_item_q.done && !b_item_q.rej,
                        !b_item_q.rej && !(in_hdr_q && is_cmd)};

  assign take_o = !b_valid_q || (out_ready_i && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      in_hdr_q  <= 1'b0;
      cnt_q     <= '0;
    end else if (take_o) begin
      b_valid_q <= valid_i;
      in_hdr_q  <= item_i.hdr;
      cnt_q     <= '0;
    end else if (out_ready_i) begin
      if (in_hdr_q && cnt_q == 4'(HDR_LEN - 1)) begin
        in_hdr_q <= 1'b0;
        cnt_q    <= '0;
      end else begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      b_item_q <= item_i;
    end
  end

endmodule
